[rtl/wsht_pkg.sv]
package wsht_pkg;

  // coordinate and window number widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned NUM_W   = 7;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  // one stack entry: four inclusive edges and the load-order number
  typedef struct packed {
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_hi;
    logic [NUM_W-1:0]   number;
  } win_entry_t;

endpackage

[rtl/window_stack_hit_test.sv]
// Window stack with click hit test and bring-to-front.
// Input channel (in_valid_i / in_stall_o) takes one word per item: op_i selects
// a load (window edges on left_i/bottom_i/right_i/top_i) or a click (point_x_i,
// point_y_i). Loads push a window on top, numbered 1, 2, ... in load order;
// loads past MAX_WINDOWS are dropped. Loads give no result.
// Each click gives one word on the output channel (out_valid_o / out_stall_i):
// hit_o and the window_number_o of the topmost window holding the point, or a
// miss with number 0. The hit window moves to the top of the stack.
// A load is written as it is taken. A click scans from the top down, reading
// each entry and then comparing it; on a hit the entries above the hit window
// shift down one place each by a read and a write, the window is placed on top
// and the result is handed over in the finish step; a miss scans every entry.
// The stack sits in a single-port-write, registered-read memory with one
// shared rectangle compare; each scan or shift step needs a read then a
// compare or write for each entry.
// in_stall_o is high while a click is being worked. A finished result waits in
// the output register while the receiver stalls; new loads are taken meanwhile,
// and a following click holds in its finish step until the register is free.
// Reset empties the stack (count to zero) and clears the output valid.
module window_stack_hit_test
  import wsht_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [COORD_W-1:0] left_i,
  input  logic [COORD_W-1:0] bottom_i,
  input  logic [COORD_W-1:0] right_i,
  input  logic [COORD_W-1:0] top_i,
  input  logic [COORD_W-1:0] point_x_i,
  input  logic [COORD_W-1:0] point_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [NUM_W-1:0]   window_number_o
);

  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_FINISH
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    idx_q;
  logic [COORD_W-1:0] px_q, py_q;
  win_entry_t         picked_q;
  logic               res_hit_q;
  logic [NUM_W-1:0]   res_num_q;
  logic               out_valid_q;
  logic               hit_q;
  logic [NUM_W-1:0]   num_q;

  // window stack memory, index 0 at the bottom
  win_entry_t         mem_q [MAX_WINDOWS];
  win_entry_t         rdata_q;
  logic [IdxW-1:0]    rd_addr;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  win_entry_t         wr_data;

  logic               in_acc;
  logic               full;
  logic               holds;
  logic [SumW-1:0]    idx_ext;
  logic [SumW-1:0]    cnt_ext;
  logic [IdxW-1:0]    top_idx;
  logic               out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CntW'(MAX_WINDOWS));
  assign idx_ext  = SumW'(idx_q);
  assign cnt_ext  = SumW'(count_q);
  assign top_idx  = IdxW'(count_q - CntW'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign window_number_o = num_q;

  // shared rectangle compare against the entry just read
  assign holds = (px_q >= rdata_q.x_lo) && (px_q <= rdata_q.x_hi) &&
                 (py_q >= rdata_q.y_lo) && (py_q <= rdata_q.y_hi);

  // memory port selection
  always_comb begin
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = top_idx;
    wr_data = picked_q;
    unique case (state_q)
      S_IDLE: begin
        wr_en   = in_acc && (op_i == OP_LOAD) && !full;
        wr_addr = IdxW'(count_q);
        wr_data = '{x_lo: left_i, y_lo: bottom_i, x_hi: right_i, y_hi: top_i,
                    number: NUM_W'(count_q) + NUM_W'(1)};
      end
      S_SHIFT_RD: rd_addr = IdxW'(idx_ext + SumW'(1));
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rdata_q;
      end
      S_PLACE: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (op_i == OP_LOAD) begin
              if (!full) begin
                count_q <= count_q + CntW'(1);
              end
            end else begin
              px_q <= point_x_i;
              py_q <= point_y_i;
              if (count_q == '0) begin
                res_hit_q <= 1'b0;
                res_num_q <= '0;
                state_q   <= S_FINISH;
              end else begin
                idx_q   <= top_idx;
                state_q <= S_SCAN_RD;
              end
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (holds) begin
            picked_q  <= rdata_q;
            res_hit_q <= 1'b1;
            res_num_q <= rdata_q.number;
            state_q   <= (idx_ext + SumW'(1) < cnt_ext) ? S_SHIFT_RD : S_PLACE;
          end else if (idx_q == '0) begin
            res_hit_q <= 1'b0;
            res_num_q <= '0;
            state_q   <= S_FINISH;
          end else begin
            idx_q   <= idx_q - IdxW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: state_q <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx_q   <= IdxW'(idx_ext + SumW'(1));
          state_q <= (idx_ext + SumW'(2) < cnt_ext) ? S_SHIFT_RD : S_PLACE;
        end
        S_PLACE: state_q <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            hit_q       <= res_hit_q;
            num_q       <= res_num_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stack fill never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_WINDOWS))
    else $error("window count above capacity");

  // an accepted load into a non-full stack bumps the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == OP_LOAD) && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("load did not advance window count");

  // count holds while a click is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |=> $stable(count_q))
    else $error("window count changed during click");

  // a new result word only comes from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result word raised outside finish");

  // a hit always carries a real window number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> num_q != '0)
    else $error("hit reported with window number zero");

endmodule
